>>> design/bcmh_pkg.sv
package bcmh_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_INC,
    S_PRD,
    S_PCMP,
    S_PLACE,
    S_TOP,
    S_RESULT
  } state_t;

  localparam int unsigned AGE_W      = 8;
  localparam int unsigned BUCKET_W   = 8;
  localparam int unsigned TOPCOUNT_W = 16;
  localparam int unsigned OCC_W      = 6;

  // age / 10 is taken as (age * 205) >> 11, exact for every 8-bit age.
  localparam int unsigned RECIP       = 205;
  localparam int unsigned RECIP_SHIFT = 11;
  localparam int unsigned PROD_W      = AGE_W + 8;

  function automatic logic [BUCKET_W-1:0] bucket_of(input logic [AGE_W-1:0] age);
    logic [PROD_W-1:0]   prod;
    logic [BUCKET_W-1:0] q;
    prod = PROD_W'(age) * PROD_W'(RECIP);
    q    = BUCKET_W'(prod >> RECIP_SHIFT);
    return BUCKET_W'((q << 3) + (q << 1));
  endfunction

endpackage

>>> design/bucket_count_max_heap.sv
// Age histogram held in a binary max-heap of (bucket, count) entries.
// Input channel: one 8-bit age per item on in_tdata. Each age is counted into
// its bucket of ten. Result channel: one item per input, giving the bucket and
// count at the heap root, the number of distinct buckets and an overflow flag
// that is set when a new bucket found the heap full and was dropped.
// The block works on one item at a time, and in_tready is high only while it
// is idle. All heap accesses go through one memory with one read and one write
// port, so the cost is set by that port. After the accepting cycle come a linear
// search that reads one entry per cycle until the bucket is found or every
// entry is read, an increment of a found count, a sift-up that reads and then
// compares the parent on each level, a write-back of an entry that went through
// sift-up, a read of the root and the presentation of the result.
// A result is held on out_tdata with out_tvalid high until out_tready is seen;
// the block takes no new item meanwhile. Reset empties the heap at once by
// clearing the fill level; no clearing pass runs over the memory.
module bucket_count_max_heap #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] age
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [7:0] top_bucket, [23:8] top_count,
                                  // [29:24] occupancy, [30] overflow, [31] zero
);

  localparam int unsigned IDX_W  = $clog2(CAPACITY);
  localparam int unsigned FILL_W = $clog2(CAPACITY + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [FILL_W-1:0]     FILL_FULL = FILL_W'(CAPACITY);

  bcmh_pkg::state_t state_r, state_nxt;

  logic [bcmh_pkg::BUCKET_W-1:0] bucket_r, bucket_nxt;
  logic [FILL_W-1:0]             issue_r, issue_nxt;
  logic                          chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0]              chk_idx_r, chk_idx_nxt;
  logic [IDX_W-1:0]              pos_r, pos_nxt;
  logic [COUNT_BITS-1:0]         cnt_r, cnt_nxt;
  logic [FILL_W-1:0]             fill_r, fill_nxt;
  logic                          ovf_r, ovf_nxt;

  logic [bcmh_pkg::BUCKET_W-1:0] mem_bucket [CAPACITY];
  logic [COUNT_BITS-1:0]         mem_count  [CAPACITY];
  logic [bcmh_pkg::BUCKET_W-1:0] rd_bucket_r;
  logic [COUNT_BITS-1:0]         rd_count_r;

  logic                          rd_en;
  logic [IDX_W-1:0]              rd_addr;
  logic                          wr_en;
  logic [IDX_W-1:0]              wr_addr;
  logic [bcmh_pkg::BUCKET_W-1:0] wr_bucket;
  logic [COUNT_BITS-1:0]         wr_count;

  logic             hit;
  logic             miss;
  logic             sat;
  logic             move_up;
  logic [IDX_W-1:0] parent_idx;
  logic [31:0]      cnt_ext;
  logic [15:0]      fill_ext;

  assign hit        = chk_v_r && (rd_bucket_r == bucket_r);
  assign miss       = !chk_v_r && (issue_r == fill_r);
  assign sat        = (cnt_r == CNT_MAX);
  assign move_up    = (cnt_r > rd_count_r);
  assign parent_idx = (pos_r - IDX_W'(1)) >> 1;
  assign cnt_ext    = 32'(rd_count_r);
  assign fill_ext   = 16'(fill_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bcmh_pkg::S_IDLE:   if (in_tvalid) state_nxt = bcmh_pkg::S_SEARCH;
      bcmh_pkg::S_SEARCH: begin
        if (hit) begin
          state_nxt = bcmh_pkg::S_INC;
        end else if (miss) begin
          state_nxt = bcmh_pkg::S_TOP;
        end
      end
      bcmh_pkg::S_INC: begin
        if (sat || pos_r == '0) begin
          state_nxt = bcmh_pkg::S_TOP;
        end else begin
          state_nxt = bcmh_pkg::S_PRD;
        end
      end
      bcmh_pkg::S_PRD:  state_nxt = bcmh_pkg::S_PCMP;
      bcmh_pkg::S_PCMP: begin
        if (move_up && parent_idx != '0) begin
          state_nxt = bcmh_pkg::S_PRD;
        end else begin
          state_nxt = bcmh_pkg::S_PLACE;
        end
      end
      bcmh_pkg::S_PLACE:  state_nxt = bcmh_pkg::S_TOP;
      bcmh_pkg::S_TOP:    state_nxt = bcmh_pkg::S_RESULT;
      bcmh_pkg::S_RESULT: if (out_tready) state_nxt = bcmh_pkg::S_IDLE;
      default:            state_nxt = bcmh_pkg::S_IDLE;
    endcase
  end

  // Outputs, memory port controls and datapath updates.
  always_comb begin
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = pos_r;
    wr_bucket   = bucket_r;
    wr_count    = cnt_r;
    bucket_nxt  = bucket_r;
    issue_nxt   = issue_r;
    chk_v_nxt   = 1'b0;
    chk_idx_nxt = chk_idx_r;
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    fill_nxt    = fill_r;
    ovf_nxt     = ovf_r;
    unique case (state_r)
      bcmh_pkg::S_IDLE: begin
        in_tready  = 1'b1;
        bucket_nxt = bcmh_pkg::bucket_of(in_tdata);
        issue_nxt  = '0;
        ovf_nxt    = 1'b0;
      end
      bcmh_pkg::S_SEARCH: begin
        if (hit) begin
          pos_nxt = chk_idx_r;
          cnt_nxt = rd_count_r;
        end else if (miss) begin
          if (fill_r == FILL_FULL) begin
            ovf_nxt = 1'b1;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = fill_r[IDX_W-1:0];
            wr_count  = COUNT_BITS'(1);
            fill_nxt  = fill_r + FILL_W'(1);
          end
        end else if (issue_r != fill_r) begin
          // Reads are pipelined: the entry issued now is compared next cycle.
          rd_en       = 1'b1;
          rd_addr     = issue_r[IDX_W-1:0];
          issue_nxt   = issue_r + FILL_W'(1);
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = issue_r[IDX_W-1:0];
        end
      end
      bcmh_pkg::S_INC: begin
        if (!sat) begin
          cnt_nxt = cnt_r + COUNT_BITS'(1);
          if (pos_r == '0) begin
            wr_en    = 1'b1;
            wr_count = cnt_r + COUNT_BITS'(1);
          end
        end
      end
      bcmh_pkg::S_PRD: begin
        rd_en   = 1'b1;
        rd_addr = parent_idx;
      end
      bcmh_pkg::S_PCMP: begin
        // The moving entry stays in registers; only the parent is shifted down.
        if (move_up) begin
          wr_en     = 1'b1;
          wr_bucket = rd_bucket_r;
          wr_count  = rd_count_r;
          pos_nxt   = parent_idx;
        end
      end
      bcmh_pkg::S_PLACE: wr_en = 1'b1;
      bcmh_pkg::S_TOP: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      bcmh_pkg::S_RESULT: out_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign out_tdata = {1'b0, ovf_r, fill_ext[bcmh_pkg::OCC_W-1:0],
                      cnt_ext[bcmh_pkg::TOPCOUNT_W-1:0], rd_bucket_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcmh_pkg::S_IDLE;
      fill_r  <= '0;
      chk_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      chk_v_r <= chk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bucket_r  <= bucket_nxt;
    issue_r   <= issue_nxt;
    chk_idx_r <= chk_idx_nxt;
    pos_r     <= pos_nxt;
    cnt_r     <= cnt_nxt;
    ovf_r     <= ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_bucket[wr_addr] <= wr_bucket;
      mem_count[wr_addr]  <= wr_count;
    end
    if (rd_en) begin
      rd_bucket_r <= mem_bucket[rd_addr];
      rd_count_r  <= mem_count[rd_addr];
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("fill level beyond capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ovf_r |-> fill_r == FILL_FULL)
    else $error("overflow reported while the heap has room");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && !out_tvalid)
    else $error("item accepted while another is in work");

  a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> fill_r != '0)
    else $error("result presented for an empty heap");

endmodule
